### rtl/tcbp_pkg.sv
// ----------------------------------------------------------------------------
// tcbp_pkg: shared definitions for the task placer
// Widths, reset values, register indexes, fit mode and state codes.
// ----------------------------------------------------------------------------
package tcbp_pkg;

   localparam int CAP_W       = 17;
   localparam int CORE_IDX_W  = 3;
   localparam int FIT_W       = 2;
   localparam int CSR_IDX_W   = 1;
   localparam int CORES_DEF   = 8;

   localparam logic [CAP_W-1:0] CAP_RESET = 17'd65536;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIT_MODE      = 1'b0,
      CSR_CORE_CAPACITY = 1'b1
   } csr_index_type;

   localparam logic [FIT_W-1:0] FIT_FIRST = 2'd0;
   localparam logic [FIT_W-1:0] FIT_BEST  = 2'd1;
   localparam logic [FIT_W-1:0] FIT_WORST = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_READ  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_WRITE = 4'b1000
   } state_type;

endpackage

### rtl/task_core_bin_packing_placer.sv
// ----------------------------------------------------------------------------
// task_core_bin_packing_placer
// Places one task per request on a core by first, best or worst fit and
// keeps the remaining capacity of every core in a memory with one read and one write port.
// ----------------------------------------------------------------------------
//   channel | dir | handshake           | payload
//   req     | in  | req_valid/req_stall | task_utilization, first_task
//   rsp     | out | rsp_valid/rsp_stall | placed, core_index, remaining_after
//   csr     | in  | csr_write           | csr_index, csr_wdata
//
// A task passes through the accept state, one memory read per core, the
// drain state for the last compare and the write-back state.
// Reset restores every core to 1.0 at once through per-core valid bits;
// first_task does the same with the configured capacity.
// A stalled result beat holds the block in write-back; a new request beat
// is taken while a finished result still waits on the output register.
// ----------------------------------------------------------------------------
module task_core_bin_packing_placer
   import tcbp_pkg::*;
#(
   parameter int CORES = CORES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CAP_W-1:0]      req_task_utilization,
   input  logic                  req_first_task,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_placed,
   output logic [CORE_IDX_W-1:0] rsp_core_index,
   output logic [CAP_W-1:0]      rsp_remaining_after,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CAP_W-1:0]      csr_wdata
);

   localparam int IDX_W = (CORES > 1) ? $clog2(CORES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CORES - 1);

   // configuration
   logic [FIT_W-1:0] fit_mode_ff;
   logic [CAP_W-1:0] core_capacity_ff;

   // capacity store
   logic [CAP_W-1:0] cap_mem [CORES];
   logic [CORES-1:0] valid_ff, valid_in;
   logic [CAP_W-1:0] reload_ff, reload_in;
   logic [CAP_W-1:0] rd_data_ff;
   logic             rd_valid_ff;

   // control
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] rd_addr_ff, rd_addr_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic [CAP_W-1:0] task_ff, task_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] pick_ff, pick_in;
   logic [CAP_W-1:0] best_ff, best_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_placed_ff, rsp_placed_in;
   logic [CORE_IDX_W-1:0] rsp_core_index_ff, rsp_core_index_in;
   logic [CAP_W-1:0]      rsp_remaining_ff, rsp_remaining_in;

   logic                  req_accept;
   logic                  out_free;
   logic                  mem_we;
   logic [CAP_W-1:0]      eff_cap;
   logic                  fits;
   logic                  take;
   logic [CAP_W-1:0]      left_cap;
   logic [IDX_W+CORE_IDX_W-1:0] pick_ext;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign eff_cap  = rd_valid_ff ? rd_data_ff : reload_ff;
   assign fits     = eff_cap > task_ff;
   assign left_cap = best_ff - task_ff;
   assign pick_ext = {{CORE_IDX_W{1'b0}}, pick_ff};
   assign mem_we   = (state_ff == ST_WRITE) && found_ff;

   // per-entry choice: first fit stops updating after the first hit
   always_comb begin
      take = 1'b0;
      if (cmp_vld_ff && fits) begin
         if (!found_ff) begin
            take = 1'b1;
         end else if (fit_mode_ff == FIT_BEST) begin
            take = eff_cap < best_ff;
         end else if (fit_mode_ff == FIT_WORST) begin
            take = eff_cap > best_ff;
         end
      end
   end

   always_comb begin
      state_in          = state_ff;
      rd_addr_in        = rd_addr_ff;
      cmp_vld_in        = 1'b0;
      cmp_idx_in        = rd_addr_ff;
      task_in           = task_ff;
      found_in          = found_ff;
      pick_in           = pick_ff;
      best_in           = best_ff;
      valid_in          = valid_ff;
      reload_in         = reload_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_placed_in     = rsp_placed_ff;
      rsp_core_index_in = rsp_core_index_ff;
      rsp_remaining_in  = rsp_remaining_ff;

      if (take) begin
         found_in = 1'b1;
         pick_in  = cmp_idx_ff;
         best_in  = eff_cap;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               task_in    = req_task_utilization;
               found_in   = 1'b0;
               rd_addr_in = '0;
               if (req_first_task) begin
                  valid_in  = '0;
                  reload_in = core_capacity_ff;
               end
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmp_vld_in = 1'b1;
            if (rd_addr_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end else begin
               rd_addr_in = rd_addr_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (found_ff) begin
               valid_in[pick_ff] = 1'b1;
            end
            // hold the write-back until the result register frees up
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_placed_in     = found_ff;
               rsp_core_index_in = found_ff ? pick_ext[CORE_IDX_W-1:0] : '0;
               rsp_remaining_in  = found_ff ? left_cap : '0;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         valid_ff         <= '0;
         reload_ff        <= CAP_RESET;
         rsp_valid_ff     <= 1'b0;
         cmp_vld_ff       <= 1'b0;
         found_ff         <= 1'b0;
         fit_mode_ff      <= FIT_FIRST;
         core_capacity_ff <= CAP_RESET;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         reload_ff    <= reload_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_vld_ff   <= cmp_vld_in;
         found_ff     <= found_in;
         if (csr_write) begin
            case (csr_index_type'(csr_index))
               CSR_FIT_MODE:      fit_mode_ff      <= csr_wdata[FIT_W-1:0];
               CSR_CORE_CAPACITY: core_capacity_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff        <= rd_addr_in;
      cmp_idx_ff        <= cmp_idx_in;
      task_ff           <= task_in;
      pick_ff           <= pick_in;
      best_ff           <= best_in;
      rsp_placed_ff     <= rsp_placed_in;
      rsp_core_index_ff <= rsp_core_index_in;
      rsp_remaining_ff  <= rsp_remaining_in;
   end

   // capacity memory: one read every cycle plus at most one write, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cap_mem[pick_ff] <= left_cap;
      end
      rd_data_ff  <= cap_mem[rd_addr_ff];
      rd_valid_ff <= valid_ff[rd_addr_ff];
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_placed          = rsp_placed_ff;
   assign rsp_core_index      = rsp_core_index_ff;
   assign rsp_remaining_after = rsp_remaining_ff;

endmodule
